// ===== rtl/core/tcmc_pkg.sv =====
// ---------------------------------------------------------------------------
// tcmc_pkg: shared types and constants for the centroid Morton encoder
// Field widths, request payload structures, register indexes and the stage
// enable bundle that the top level hands to each axis lane.
// ---------------------------------------------------------------------------
`default_nettype none

package tcmc_pkg;

    localparam int CoordWidth      = 32;
    localparam int TagFieldWidth   = 24;
    localparam int CodeWidth       = 60;
    localparam int NumAxes         = 3;
    localparam int CfgIndexWidth   = 3;
    localparam int ScaleWidth      = 32;
    localparam int ScaleHalf       = ScaleWidth / 2;
    // Sum of three coordinates, and three times the scene minimum.
    localparam int SumWidth        = CoordWidth + 2;
    // Product of the offset magnitude with one half of the scale.
    localparam int ProdWidth       = SumWidth + ScaleHalf;
    // Full quotient of (offset * scale) >> 32.
    localparam int QuotWidth       = SumWidth;

    localparam int AxisBitsDefault = 20;
    localparam int TagWidthDefault = 24;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_SCENE_MIN_X  = 3'd0,
        CFG_SCENE_MIN_Y  = 3'd1,
        CFG_SCENE_MIN_Z  = 3'd2,
        CFG_AXIS_SCALE_X = 3'd3,
        CFG_AXIS_SCALE_Y = 3'd4,
        CFG_AXIS_SCALE_Z = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] vertex_a_x;
        logic signed [CoordWidth-1:0] vertex_a_y;
        logic signed [CoordWidth-1:0] vertex_a_z;
        logic signed [CoordWidth-1:0] vertex_b_x;
        logic signed [CoordWidth-1:0] vertex_b_y;
        logic signed [CoordWidth-1:0] vertex_b_z;
        logic signed [CoordWidth-1:0] vertex_c_x;
        logic signed [CoordWidth-1:0] vertex_c_y;
        logic signed [CoordWidth-1:0] vertex_c_z;
        logic [TagFieldWidth-1:0]     triangle_tag;
        logic                         last_in;
    } tcmc_in_t;

    typedef struct packed {
        logic [CodeWidth-1:0]     morton_code;
        logic [TagFieldWidth-1:0] tag_out;
        logic                     last_out;
        logic                     clamped;
    } tcmc_out_t;

    typedef struct packed {
        logic en_sum;
        logic en_offset;
        logic en_mult;
        logic en_quant;
    } tcmc_stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/core/triangle_centroid_morton_code_core.sv =====
// ---------------------------------------------------------------------------
// triangle_centroid_morton_code_core: triangle centroid to 60-bit Morton code
// Three axis lanes quantise the centroid of each triangle into the scene box
// and a merging stage interleaves the results into one code.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  s_        in         s_valid / s_ready     tcmc_in_t  (nine coordinates, tag, last)
//  m_        out        m_valid / m_ready     tcmc_out_t (code, tag, last, clamped)
//  cfg_      in         cfg_wr_en             cfg_index, cfg_wdata (no read-back)
//
// One request is accepted every clock cycle while m_ready does not stall the
// output. The accepting edge loads the first lane step (sum); the request then
// passes through three further lane steps (offset, multiply, saturate) and the
// output register before it is on m_data. The throughput is set by the single
// pass through each lane's two 34x16 multipliers, which are fully pipelined.
// Reset is synchronous and active low; it empties the pipeline and clears all
// six configuration registers. A stall on m_ready only holds the stages that
// are occupied, so bubbles further up still fill and s_ready stays high until
// every stage is full.
`default_nettype none

module triangle_centroid_morton_code_core #(
    parameter int AXIS_BITS = tcmc_pkg::AxisBitsDefault,
    parameter int TAG_WIDTH = tcmc_pkg::TagWidthDefault
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire tcmc_pkg::tcmc_in_t                   s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output tcmc_pkg::tcmc_out_t                       m_data,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [tcmc_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [tcmc_pkg::ScaleWidth-1:0]      cfg_wdata
);

    localparam int Stages  = 4;
    localparam int TagKeep = (TAG_WIDTH < tcmc_pkg::TagFieldWidth) ?
                             TAG_WIDTH : tcmc_pkg::TagFieldWidth;
    localparam int SW      = tcmc_pkg::SumWidth;
    localparam int CW      = tcmc_pkg::CoordWidth;

    // The scene minimum is kept as three times its value, which is all the
    // offset step ever needs. Working it out at write time keeps the
    // multiply by three off the request path.
    logic signed [SW-1:0]               min3_reg  [tcmc_pkg::NumAxes];
    logic [tcmc_pkg::ScaleWidth-1:0]    scale_reg [tcmc_pkg::NumAxes];
    logic signed [SW-1:0]               min3_wr;

    logic [Stages-1:0]                  valid_reg, valid_next;
    logic [Stages-1:0]                  load;
    logic [TagKeep-1:0]                 tag_reg  [Stages];
    logic                               last_reg [Stages];
    logic                               out_load;
    tcmc_pkg::tcmc_stage_en_t           stage_en;

    logic [tcmc_pkg::NumAxes-1:0][AXIS_BITS-1:0] lane_values;
    logic [tcmc_pkg::NumAxes-1:0]                lane_sats;

    // Configuration writes. Indexes beyond the register list are ignored.
    always_comb begin
        min3_wr = $signed({{(SW-CW){cfg_wdata[CW-1]}}, cfg_wdata})
                + $signed({cfg_wdata[CW-1], cfg_wdata, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < tcmc_pkg::NumAxes; a++) begin
                min3_reg[a]  <= '0;
                scale_reg[a] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (tcmc_pkg::cfg_index_t'(cfg_index))
                tcmc_pkg::CFG_SCENE_MIN_X:  min3_reg[0]  <= min3_wr;
                tcmc_pkg::CFG_SCENE_MIN_Y:  min3_reg[1]  <= min3_wr;
                tcmc_pkg::CFG_SCENE_MIN_Z:  min3_reg[2]  <= min3_wr;
                tcmc_pkg::CFG_AXIS_SCALE_X: scale_reg[0] <= cfg_wdata;
                tcmc_pkg::CFG_AXIS_SCALE_Y: scale_reg[1] <= cfg_wdata;
                tcmc_pkg::CFG_AXIS_SCALE_Z: scale_reg[2] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Each stage loads when it is empty or when the stage after it is
    // loading too, so the pipeline closes up its bubbles under a stall.
    always_comb begin
        load[3] = !valid_reg[3] || out_load;
        load[2] = !valid_reg[2] || load[3];
        load[1] = !valid_reg[1] || load[2];
        load[0] = !valid_reg[0] || load[1];

        valid_next[0] = load[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < Stages; k++) begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end

        stage_en.en_sum    = load[0];
        stage_en.en_offset = load[1];
        stage_en.en_mult   = load[2];
        stage_en.en_quant  = load[3];
    end

    assign s_ready = load[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The tag and last mark travel beside the lanes.
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            tag_reg[0]  <= s_data.triangle_tag[TagKeep-1:0];
            last_reg[0] <= s_data.last_in;
        end
        for (int k = 1; k < Stages; k++) begin
            if (load[k]) begin
                tag_reg[k]  <= tag_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    tcmc_axis_lane #(.AXIS_BITS(AXIS_BITS)) u_lane_x (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .coord_a    (s_data.vertex_a_x),
        .coord_b    (s_data.vertex_b_x),
        .coord_c    (s_data.vertex_c_x),
        .min_times3 (min3_reg[0]),
        .scale      (scale_reg[0]),
        .axis_value (lane_values[0]),
        .axis_sat   (lane_sats[0])
    );

    tcmc_axis_lane #(.AXIS_BITS(AXIS_BITS)) u_lane_y (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .coord_a    (s_data.vertex_a_y),
        .coord_b    (s_data.vertex_b_y),
        .coord_c    (s_data.vertex_c_y),
        .min_times3 (min3_reg[1]),
        .scale      (scale_reg[1]),
        .axis_value (lane_values[1]),
        .axis_sat   (lane_sats[1])
    );

    tcmc_axis_lane #(.AXIS_BITS(AXIS_BITS)) u_lane_z (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .coord_a    (s_data.vertex_a_z),
        .coord_b    (s_data.vertex_b_z),
        .coord_c    (s_data.vertex_c_z),
        .min_times3 (min3_reg[2]),
        .scale      (scale_reg[2]),
        .axis_value (lane_values[2]),
        .axis_sat   (lane_sats[2])
    );

    tcmc_merge #(
        .AXIS_BITS (AXIS_BITS),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_reg[Stages-1]),
        .in_values (lane_values),
        .in_sats   (lane_sats),
        .in_tag    (tag_reg[Stages-1]),
        .in_last   (last_reg[Stages-1]),
        .out_load  (out_load),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tcmc_axis_lane.sv =====
// ---------------------------------------------------------------------------
// tcmc_axis_lane: one axis of the centroid quantiser
// Four registered steps: vertex sum, offset from the scene minimum, split
// multiplication by the axis scale, then shift and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module tcmc_axis_lane #(
    parameter int AXIS_BITS = tcmc_pkg::AxisBitsDefault
) (
    input  wire logic                                    aclk,
    input  wire tcmc_pkg::tcmc_stage_en_t                stage_en,
    input  wire logic signed [tcmc_pkg::CoordWidth-1:0]  coord_a,
    input  wire logic signed [tcmc_pkg::CoordWidth-1:0]  coord_b,
    input  wire logic signed [tcmc_pkg::CoordWidth-1:0]  coord_c,
    input  wire logic signed [tcmc_pkg::SumWidth-1:0]    min_times3,
    input  wire logic [tcmc_pkg::ScaleWidth-1:0]         scale,
    output logic [AXIS_BITS-1:0]                         axis_value,
    output logic                                         axis_sat
);

    localparam int SW = tcmc_pkg::SumWidth;
    localparam int PW = tcmc_pkg::ProdWidth;
    localparam int QW = tcmc_pkg::QuotWidth;
    localparam int HW = tcmc_pkg::ScaleHalf;
    localparam int CW = tcmc_pkg::CoordWidth;

    logic signed [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0]        mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [PW-1:0]        prod_hi_reg, prod_hi_next;
    logic [PW-1:0]        prod_lo_reg, prod_lo_next;
    logic                 neg_m_reg;
    logic [AXIS_BITS-1:0] value_reg, value_next;
    logic                 sat_reg, sat_next;
    logic signed [SW:0]   offset;
    logic [PW-1:0]        prod_sum;
    logic [QW-1:0]        quot;

    always_comb begin
        sum_next = $signed({{(SW-CW){coord_a[CW-1]}}, coord_a})
                 + $signed({{(SW-CW){coord_b[CW-1]}}, coord_b})
                 + $signed({{(SW-CW){coord_c[CW-1]}}, coord_c});

        offset   = $signed({sum_reg[SW-1], sum_reg}) - $signed({min_times3[SW-1], min_times3});
        neg_next = offset[SW];
        mag_next = offset[SW-1:0];

        prod_hi_next = PW'(mag_reg) * PW'(scale[2*HW-1:HW]);
        prod_lo_next = PW'(mag_reg) * PW'(scale[HW-1:0]);

        // The low partial product only contributes its bits above the
        // first sixteen; the result is exact floor((d * scale) / 2^32).
        prod_sum = prod_hi_reg + PW'(prod_lo_reg[PW-1:HW]);
        quot     = prod_sum[QW+HW-1:HW];

        if (neg_m_reg) begin
            value_next = '0;
            sat_next   = 1'b1;
        end else if (|quot[QW-1:AXIS_BITS]) begin
            value_next = '1;
            sat_next   = 1'b1;
        end else begin
            value_next = quot[AXIS_BITS-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.en_sum) begin
            sum_reg <= sum_next;
        end
        if (stage_en.en_offset) begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        if (stage_en.en_mult) begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            neg_m_reg   <= neg_reg;
        end
        if (stage_en.en_quant) begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign axis_value = value_reg;
    assign axis_sat   = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tcmc_merge.sv =====
// ---------------------------------------------------------------------------
// tcmc_merge: bit interleave and output register
// Combines the three axis values into the Morton code, gathers the
// saturation flags and holds the finished request until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module tcmc_merge #(
    parameter int AXIS_BITS = tcmc_pkg::AxisBitsDefault,
    parameter int TAG_WIDTH = tcmc_pkg::TagWidthDefault
) (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire logic                                              in_valid,
    input  wire logic [tcmc_pkg::NumAxes-1:0][AXIS_BITS-1:0]       in_values,
    input  wire logic [tcmc_pkg::NumAxes-1:0]                      in_sats,
    input  wire logic [((TAG_WIDTH < tcmc_pkg::TagFieldWidth) ?
                        TAG_WIDTH : tcmc_pkg::TagFieldWidth)-1:0]  in_tag,
    input  wire logic                                              in_last,
    output logic                                                   out_load,
    output logic                                                   out_valid,
    input  wire logic                                              out_ready,
    output tcmc_pkg::tcmc_out_t                                    out_data
);

    logic                 valid_reg, valid_next;
    tcmc_pkg::tcmc_out_t  data_reg, data_next;
    logic [tcmc_pkg::CodeWidth-1:0] code;

    always_comb begin
        code = '0;
        for (int k = 0; k < AXIS_BITS; k++) begin
            for (int a = 0; a < tcmc_pkg::NumAxes; a++) begin
                if (3 * k + a < tcmc_pkg::CodeWidth) begin
                    code[3 * k + a] = in_values[a][k];
                end
            end
        end

        data_next.morton_code = code;
        data_next.tag_out     = tcmc_pkg::TagFieldWidth'(in_tag);
        data_next.last_out    = in_last;
        data_next.clamped     = |in_sats;

        out_load   = !valid_reg || out_ready;
        valid_next = out_load ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tcmc_checker.sv =====
// ---------------------------------------------------------------------------
// tcmc_checker: port-level checks for the centroid Morton encoder
// Watches the request channels and tracks how many requests are in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module tcmc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire tcmc_pkg::tcmc_out_t m_data
);

    // Four lane steps plus the output register.
    localparam logic [2:0] MaxInFlight = 3'd5;

    logic [2:0] count_reg, count_next;
    logic       in_acc, out_acc;

    always_comb begin
        in_acc     = s_valid && s_ready;
        out_acc    = m_valid && m_ready;
        count_next = count_reg + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // A held result keeps its contents until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result without a request that caused it.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> count_reg != 3'd0)
        else $error("result shown with nothing in flight");

    // The pipeline never holds more than its depth.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxInFlight)
        else $error("more requests in flight than pipeline stages");

    // With the output register empty, every stage can advance.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output is empty");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind triangle_centroid_morton_code_core tcmc_checker u_tcmc_checker (.*);

`default_nettype wire
